// ----- sv/bpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types for the byte pattern first-match search
// Holds the decoded operation codes and the item format that passes from
// the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfm_pkg;

  // Depth of the queue between front and back end, and its pointer width.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // Operation that the back end carries out for one beat.
  typedef enum logic [1:0] {
    OP_PAT_START  = 2'd0,  // first byte of a new pattern
    OP_PAT_APPEND = 2'd1,  // further byte of the open pattern
    OP_TEXT       = 2'd2,  // region byte, more to follow
    OP_TEXT_LAST  = 2'd3   // final region byte, produces a result
  } op_e;

  // Decoded item as it travels through the queue.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/bpfm_front.sv -----
// ----------------------------------------------------------------------------
// bpfm_front: input decode for the byte pattern first-match search
// Accepts beats from the input stream, tracks whether a pattern is open and
// turns each beat into an operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            action_i,
  input  wire logic [7:0]      data_i,
  input  wire logic            last_i,
  input  wire logic            push_ready_i,
  output bpfm_pkg::item_t      push_item_o,
  output logic                 push_valid_o
);

  logic pat_closed_q, pat_closed_d;
  logic accept;

  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i;

  // Classify the beat; a pattern byte after a closed pattern starts afresh.
  always_comb begin
    push_item_o.data = data_i;
    if (action_i) begin
      push_item_o.op = last_i ? bpfm_pkg::OP_TEXT_LAST : bpfm_pkg::OP_TEXT;
    end else begin
      push_item_o.op = pat_closed_q ? bpfm_pkg::OP_PAT_START : bpfm_pkg::OP_PAT_APPEND;
    end
  end

  // The marker on a pattern byte closes the pattern; text leaves it alone.
  always_comb begin
    pat_closed_d = pat_closed_q;
    if (accept && !action_i) begin
      pat_closed_d = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_closed_q <= 1'b1;
    end else begin
      pat_closed_q <= pat_closed_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpfm_fifo.sv -----
// ----------------------------------------------------------------------------
// bpfm_fifo: short queue between front and back end
// Two-entry queue of decoded items so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  input  wire bpfm_pkg::item_t push_item_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output bpfm_pkg::item_t      pop_item_o,
  input  wire logic            pop_ready_i
);

  localparam int unsigned CW = bpfm_pkg::QUEUE_AW + 1;

  bpfm_pkg::item_t                  mem_q [bpfm_pkg::QUEUE_DEPTH];
  logic [bpfm_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [bpfm_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                    count_q, count_d;
  logic                             push, pop;

  assign push_ready_o = (count_q != CW'(bpfm_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are read only after a write.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpfm_back.sv -----
// ----------------------------------------------------------------------------
// bpfm_back: pattern store, text window and match engine
// Carries out one decoded operation per cycle unless a final region byte
// waits on a full output register. Pattern and window shift in at lane 0,
// so pattern lane j always meets window lane j in a fixed byte compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_back #(
  parameter int unsigned PATTERN_MAX    = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire bpfm_pkg::item_t item_i,
  output logic                 item_ready_o,
  output logic                 res_valid_o,
  output logic                 res_found_o,
  output logic [31:0]          res_offset_o,
  input  wire logic            res_ready_i
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned CW = (PW > LW) ? PW : LW;
  localparam int unsigned OW = (PW > 32) ? PW : 32;

  logic [7:0]    pat_q [PATTERN_MAX];
  logic [7:0]    pat_d [PATTERN_MAX];
  logic [7:0]    win_q [PATTERN_MAX];
  logic [7:0]    win_d [PATTERN_MAX];
  logic [LW-1:0] len_q, len_d;
  logic [PW-1:0] seen_q, seen_d, seen_inc;
  logic          match_q, match_d;
  logic [PW-1:0] first_q, first_d, off_now;
  logic          out_valid_q, out_valid_d;
  logic          out_found_q, out_found_d;
  logic [31:0]   out_off_q, out_off_d;

  logic                 fire, is_text, is_last, hit, all_eq, seen_ge;
  logic [PATTERN_MAX-1:0] lane_ok;
  logic [OW-1:0]        off_ext;

  assign is_text      = (item_i.op == bpfm_pkg::OP_TEXT) ||
                        (item_i.op == bpfm_pkg::OP_TEXT_LAST);
  assign is_last      = (item_i.op == bpfm_pkg::OP_TEXT_LAST);
  // Only a final region byte needs room in the output register.
  assign item_ready_o = !(is_last && out_valid_q && !res_ready_i);
  assign fire         = item_valid_i && item_ready_o;

  // Window after this byte is shifted in, and the saturating position.
  always_comb begin
    for (int j = PATTERN_MAX - 1; j > 0; j--) begin
      win_d[j] = win_q[j-1];
    end
    win_d[0] = item_i.data;
    seen_inc = (seen_q != '1) ? seen_q + 1'b1 : seen_q;
  end

  // Parallel byte compares, masked to the current pattern length.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      lane_ok[j] = (pat_q[j] == win_d[j]) || !(LW'(j) < len_q);
    end
    all_eq  = &lane_ok;
    seen_ge = CW'(seen_inc) >= CW'(len_q);
    hit     = (len_q != '0) && seen_ge && all_eq;
    off_now = PW'(CW'(seen_inc) - CW'(len_q));
  end

  // Operation execution.
  always_comb begin
    pat_d   = pat_q;
    len_d   = len_q;
    seen_d  = seen_q;
    match_d = match_q;
    first_d = first_q;
    off_ext     = OW'(match_q ? first_q : off_now);
    out_found_d = out_found_q;
    out_off_d   = out_off_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (fire) begin
      unique case (item_i.op)
        bpfm_pkg::OP_PAT_START: begin
          for (int j = PATTERN_MAX - 1; j > 0; j--) begin
            pat_d[j] = pat_q[j-1];
          end
          pat_d[0] = item_i.data;
          len_d    = LW'(1);
        end
        bpfm_pkg::OP_PAT_APPEND: begin
          if (len_q != LW'(PATTERN_MAX)) begin
            for (int j = PATTERN_MAX - 1; j > 0; j--) begin
              pat_d[j] = pat_q[j-1];
            end
            pat_d[0] = item_i.data;
            len_d    = len_q + 1'b1;
          end
        end
        bpfm_pkg::OP_TEXT: begin
          seen_d = seen_inc;
          if (!match_q && hit) begin
            match_d = 1'b1;
            first_d = off_now;
          end
        end
        bpfm_pkg::OP_TEXT_LAST: begin
          // Report, then clear the region state for the next region.
          out_valid_d = 1'b1;
          out_found_d = match_q || hit;
          out_off_d   = (match_q || hit) ? off_ext[31:0] : 32'd0;
          seen_d      = '0;
          match_d     = 1'b0;
          first_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Window register update, kept apart from the shifted view used above.
  logic [7:0] win_n [PATTERN_MAX];

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (fire && is_text) begin
        win_n[j] = is_last ? 8'd0 : win_d[j];
      end else begin
        win_n[j] = win_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      seen_q      <= '0;
      match_q     <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_q[j] <= 8'd0;
      end
    end else begin
      len_q       <= len_d;
      seen_q      <= seen_d;
      match_q     <= match_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_q[j] <= win_n[j];
      end
    end
  end

  // Pattern lanes and the result payload carry no reset.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat_q[j] <= pat_d[j];
    end
    out_found_q <= out_found_d;
    out_off_q   <= out_off_d;
  end

  assign res_valid_o  = out_valid_q;
  assign res_found_o  = out_found_q;
  assign res_offset_o = out_off_q;

endmodule

`default_nettype wire

// ----- sv/byte_pattern_first_match.sv -----
// ----------------------------------------------------------------------------
// byte_pattern_first_match: first occurrence of a byte pattern in a region
// Pattern beats load a pattern store, region beats shift a text window that
// is compared against the pattern; the final region beat returns a result.
//
//   Channel  Dir  tdata                  tuser   tlast
//   s_axis   in   [7:0] data_byte        action  last_byte
//   m_axis   out  [31:0] match_offset    found   -
//
// One beat per cycle is sustained: the front end takes a beat every cycle
// the two-entry queue has room, and the back end retires one operation per
// cycle through its combinational lane compare; results leave through the
// result register. Reset clears the queue, pattern length, window and
// counters at once; no clearing pass is needed. Only a final region beat
// waits on a full output register; other beats proceed under output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_first_match #(
  parameter int unsigned PATTERN_MAX    = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] action
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] match_offset
  output logic             m_axis_tuser_o    // [0] found
);

  bpfm_pkg::item_t push_item, pop_item;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  // Decode input beats into operations.
  bpfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .action_i     (s_axis_tuser_i),
    .data_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .push_ready_i (push_ready),
    .push_item_o  (push_item),
    .push_valid_o (push_valid)
  );

  assign s_axis_tready_o = push_ready;

  // Queue between the two halves.
  bpfm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Pattern store, window and result register.
  bpfm_back #(
    .PATTERN_MAX    (PATTERN_MAX),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .res_valid_o  (m_axis_tvalid_o),
    .res_found_o  (m_axis_tuser_o),
    .res_offset_o (m_axis_tdata_o),
    .res_ready_i  (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// ----- dv/bpfm_checker.sv -----
// ----------------------------------------------------------------------------
// bpfm_checker: result checker for the byte pattern first-match search
// Watches both stream channels. Every accepted input beat updates a private
// copy of the pattern store and text window; a final region beat queues the
// expected search result, which is compared field by field with the next
// result beat that leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_checker #(
  parameter int unsigned PATTERN_MAX    = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] action
  input  wire logic        s_axis_tlast_i,   // last_byte
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [31:0] m_axis_tdata_i,   // [31:0] match_offset
  input  wire logic        m_axis_tuser_i,   // [0] found
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               hits_o
);

  // One search result as the block reports it.
  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } search_result_t;

  // Private copy of the search state.
  logic [7:0]                pat_bytes [PATTERN_MAX];
  int unsigned               pat_len;
  bit                        pat_closed;
  logic [7:0]                text_win [PATTERN_MAX];
  logic [POSITION_WIDTH-1:0] region_pos;
  bit                        hit_seen;
  logic [POSITION_WIDTH-1:0] hit_pos;

  search_result_t expected_results[$];
  int error_cnt;
  int result_cnt;
  int hit_cnt;

  // The newest window byte sits at index 0, so pattern byte k lines up with
  // window byte len-1-k.
  function automatic bit window_hits();
    if (pat_len == 0 || pat_len > PATTERN_MAX) return 1'b0;
    if (64'(region_pos) < 64'(pat_len)) return 1'b0;
    for (int k = 0; k < int'(pat_len); k++) begin
      if (pat_bytes[k] != text_win[int'(pat_len) - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_region();
    foreach (text_win[i]) text_win[i] = 8'h00;
    region_pos = '0;
    hit_seen   = 1'b0;
    hit_pos    = '0;
  endfunction

  // Apply one input beat to the copy of the state; a final region beat
  // yields the expected result.
  function automatic void search_beat(input bit is_text, input logic [7:0] data,
                                      input bit last);
    search_result_t res;
    if (!is_text) begin
      if (pat_closed) begin
        pat_len    = 0;
        pat_closed = 1'b0;
      end
      if (pat_len < PATTERN_MAX) begin
        pat_bytes[pat_len] = data;
        pat_len++;
      end
      if (last) pat_closed = 1'b1;
      return;
    end
    for (int i = PATTERN_MAX - 1; i > 0; i--) text_win[i] = text_win[i-1];
    text_win[0] = data;
    if (region_pos != '1) region_pos++;
    if (!hit_seen && window_hits()) begin
      hit_seen = 1'b1;
      hit_pos  = region_pos - POSITION_WIDTH'(pat_len);
    end
    if (!last) return;
    res.found  = hit_seen;
    res.offset = hit_seen ? 32'(hit_pos) : 32'd0;
    expected_results.insert(expected_results.size(), res);
    clear_region();
  endfunction

  // Sample both channels at the rising edge and compare results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t want;
    if (!rst_ni) begin
      foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
      pat_len    = 0;
      pat_closed = 1'b1;
      clear_region();
      expected_results.delete();
      error_cnt  = 0;
      result_cnt = 0;
      hit_cnt    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        search_beat(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected result beat found=%0b offset=%0d", $time,
                   m_axis_tuser_i, m_axis_tdata_i);
        end else begin
          want = expected_results.pop_front();
          result_cnt++;
          if (want.found) hit_cnt++;
          if (m_axis_tuser_i !== want.found) begin
            error_cnt++;
            $display("%0t: found mismatch, expected %0b, actual %0b", $time,
                     want.found, m_axis_tuser_i);
          end
          if (m_axis_tdata_i !== want.offset) begin
            error_cnt++;
            $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                     $time, want.offset, m_axis_tdata_i);
          end
        end
      end
    end
    errors_o  <= error_cnt;
    pending_o <= expected_results.size();
    results_o <= result_cnt;
    hits_o    <= hit_cnt;
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for byte_pattern_first_match
// Drives pattern and region beats under three handshake idling profiles: a
// short directed run over the special cases, then random pattern/region
// sequences with planted matches and some noise. A separate checker module
// predicts and compares every result; this module only reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned PATTERN_MAX  = 32;
  localparam int          RANDOM_BEATS = 600;
  localparam int          CYCLE_LIMIT  = 400000;

  // Meaning of the tuser bit on the input channel.
  localparam bit ACT_PATTERN = 1'b0;
  localparam bit ACT_TEXT    = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int errors;
  int pending;
  int results;
  int hits;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_sent;
  int cycles;

  // Pattern of the current sequence and its alphabet, kept for planting.
  logic [7:0] pat_q[$];
  logic [7:0] sym_a;
  logic [7:0] sym_b;

  byte_pattern_first_match #(
    .PATTERN_MAX    (PATTERN_MAX),
    .POSITION_WIDTH (32)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  bpfm_checker #(
    .PATTERN_MAX    (PATTERN_MAX),
    .POSITION_WIDTH (32)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .hits_o          (hits)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result backpressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("FAIL byte_pattern_first_match");
      $finish;
    end
  end

  // Send one input beat, idling at random first, and wait for its handshake.
  task automatic send_beat(input bit act, input logic [7:0] data, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Draw a byte mostly from the two-symbol alphabet so matches stay likely.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? sym_a : sym_b;
  endfunction

  function automatic void new_alphabet();
    sym_a = 8'($urandom_range(0, 255));
    sym_b = sym_a ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  // Load a pattern of len bytes; closed puts the last marker on its final byte.
  task automatic send_pattern(input int len, input bit closed);
    logic [7:0] b;
    pat_q.delete();
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      if (pat_q.size() < PATTERN_MAX) pat_q.insert(pat_q.size(), b);
      send_beat(ACT_PATTERN, b, closed && (i == len - 1));
    end
  endtask

  // Scan a region of len bytes, optionally with the pattern planted inside.
  task automatic send_region(input int len, input bit plant);
    logic [7:0] region[$];
    int at;
    for (int i = 0; i < len; i++) region.insert(region.size(), pick_byte());
    if (plant && pat_q.size() > 0 && pat_q.size() <= len) begin
      at = $urandom_range(0, len - pat_q.size());
      foreach (pat_q[k]) region[at + k] = pat_q[k];
    end
    foreach (region[i]) send_beat(ACT_TEXT, region[i], i == len - 1);
  endtask

  // Random sequences until this phase has sent its share of beats.
  task automatic run_random(input int beats);
    int stop_at;
    int kind;
    int plen;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      new_alphabet();
      if (kind <= 6) begin
        // Closed pattern, usually short, now and then past the store size.
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, PATTERN_MAX + 4)
                                           : $urandom_range(1, 4);
        send_pattern(plen, 1'b1);
        send_region($urandom_range(1, pat_q.size() + 6), $urandom_range(0, 1));
      end else if (kind == 7) begin
        // Another region against whatever pattern is loaded.
        send_region($urandom_range(1, 12), 1'b0);
      end else if (kind == 8) begin
        // Open pattern, later bytes may extend it.
        send_pattern($urandom_range(1, 3), 1'b0);
        send_region($urandom_range(1, 8), $urandom_range(0, 1));
      end else begin
        // Noise, including pattern beats in the middle of a region.
        repeat ($urandom_range(1, 8)) begin
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = ACT_PATTERN;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 65;
    beats_sent    = 0;
    cycles        = 0;
    sym_a         = 8'h00;
    sym_b         = 8'h01;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty pattern right after reset never matches.
    send_beat(ACT_TEXT, 8'h00, 1'b1);
    // Single all-ones byte found at offset one.
    send_beat(ACT_PATTERN, 8'hFF, 1'b1);
    send_beat(ACT_TEXT, 8'h00, 1'b0);
    send_beat(ACT_TEXT, 8'hFF, 1'b1);
    // Repeated pattern reports only the first occurrence.
    send_beat(ACT_PATTERN, 8'h00, 1'b0);
    send_beat(ACT_PATTERN, 8'h80, 1'b1);
    send_beat(ACT_TEXT, 8'h00, 1'b0);
    send_beat(ACT_TEXT, 8'h80, 1'b0);
    send_beat(ACT_TEXT, 8'h00, 1'b0);
    send_beat(ACT_TEXT, 8'h80, 1'b1);
    // A pattern running past the end of the region does not match.
    send_beat(ACT_PATTERN, 8'h12, 1'b0);
    send_beat(ACT_PATTERN, 8'h34, 1'b0);
    send_beat(ACT_PATTERN, 8'h56, 1'b1);
    send_beat(ACT_TEXT, 8'h12, 1'b0);
    send_beat(ACT_TEXT, 8'h34, 1'b1);
    // An open pattern matches with the bytes loaded so far.
    send_beat(ACT_PATTERN, 8'hA5, 1'b0);
    send_beat(ACT_TEXT, 8'hA5, 1'b1);
    // The open pattern is extended, then replaced in the middle of a region.
    send_beat(ACT_PATTERN, 8'h5A, 1'b1);
    send_beat(ACT_TEXT, 8'hA5, 1'b0);
    send_beat(ACT_PATTERN, 8'h01, 1'b1);
    send_beat(ACT_TEXT, 8'h01, 1'b1);

    run_random(RANDOM_BEATS / 3);
    send_idle_pct = 65;
    recv_idle_pct = 34;
    run_random(RANDOM_BEATS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_BEATS / 3);
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then give the pipeline time to settle.
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d input beats and %0d search results, %0d with a match,",
             beats_sent, results, hits);
    $display("under three idling profiles of the sender and the receiver.");
    if (errors == 0) begin
      $display("PASS byte_pattern_first_match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL byte_pattern_first_match");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- byte_pattern_first_match.f -----
sv/bpfm_pkg.sv
sv/bpfm_front.sv
sv/bpfm_fifo.sv
sv/bpfm_back.sv
sv/byte_pattern_first_match.sv
dv/bpfm_checker.sv
dv/tb.sv
